// ----- hw/rtl/hnc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and jamo lookup functions for the Hangul converter.
// Depends on nothing; the converter modules, the checker and the testbench import it.
package hnc_pkg;

  localparam int unsigned BATCH_SLOTS = 6;

  localparam logic [7:0] SHIFT_OUT = 8'h0E;
  localparam logic [7:0] SHIFT_IN  = 8'h0F;
  localparam logic [7:0] NEWLINE   = 8'h0A;

  // Action codes of an input item.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  // Syllable phase codes.
  localparam logic [1:0] PH_NONE    = 2'd0;
  localparam logic [1:0] PH_INITIAL = 2'd1;
  localparam logic [1:0] PH_MEDIAL  = 2'd2;

  // Result bytes of one item; a set mask bit marks a slot that is sent.
  typedef struct packed {
    logic [BATCH_SLOTS-1:0]      mask;
    logic [BATCH_SLOTS-1:0][7:0] bytes;
  } batch_t;

  // A code is in range when its top bit is set and its offset is small.
  function automatic logic code_in_range(input logic [7:0] code);
    return code[7] && (code[6:5] == 2'b00);
  endfunction

  function automatic logic [7:0] initial_letter(input logic [7:0] code);
    logic [7:0] r;
    r = 8'h00;
    if (code_in_range(code)) begin
      unique case (code[4:0])
        5'd1:  r = "A";
        5'd2:  r = "B";
        5'd3:  r = "D";
        5'd4:  r = "G";
        5'd5:  r = "H";
        5'd6:  r = "I";
        5'd7:  r = "Q";
        5'd8:  r = "R";
        5'd9:  r = "S";
        5'd10: r = "U";
        5'd11: r = "V";
        5'd12: r = "W";
        5'd13: r = "X";
        5'd14: r = "Y";
        5'd15: r = "Z";
        5'd16: r = "[";
        5'd17: r = "\\";
        5'd18: r = "]";
        5'd19: r = "^";
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] medial_letter(input logic [7:0] code);
    logic [7:0] r;
    r = 8'h00;
    if (code_in_range(code)) begin
      unique case (code[4:0])
        5'd1:  r = "b";
        5'd2:  r = "c";
        5'd3:  r = "d";
        5'd4:  r = "e";
        5'd5:  r = "f";
        5'd6:  r = "g";
        5'd7:  r = "j";
        5'd8:  r = "k";
        5'd9, 5'd10, 5'd11, 5'd12: r = "l";
        5'd13: r = "r";
        5'd14, 5'd15, 5'd16, 5'd17: r = "s";
        5'd18: r = "w";
        5'd19, 5'd20: r = "z";
        5'd21: r = "|";
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] medial_extra_letter(input logic [7:0] code);
    logic [7:0] r;
    r = 8'h00;
    if (code_in_range(code)) begin
      unique case (code[4:0])
        5'd10: r = "b";
        5'd11: r = "c";
        5'd12, 5'd17, 5'd20: r = "|";
        5'd15: r = "f";
        5'd16: r = "g";
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] final_letter(input logic [7:0] code);
    logic [7:0] r;
    r = 8'h00;
    if (code_in_range(code)) begin
      unique case (code[4:0])
        5'd1, 5'd3:  r = "A";
        5'd2:        r = "B";
        5'd4, 5'd5, 5'd6: r = "D";
        5'd7:        r = "G";
        5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15: r = "I";
        5'd16:       r = "Q";
        5'd17, 5'd18: r = "R";
        5'd19:       r = "U";
        5'd20:       r = "V";
        5'd21:       r = "W";
        5'd22:       r = "X";
        5'd23:       r = "Z";
        5'd24:       r = "[";
        5'd25:       r = "\\";
        5'd26:       r = "]";
        5'd27:       r = "^";
        default:     r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] final_extra_letter(input logic [7:0] code);
    logic [7:0] r;
    r = 8'h00;
    if (code_in_range(code)) begin
      unique case (code[4:0])
        5'd3, 5'd12, 5'd18: r = "U";
        5'd5:  r = "X";
        5'd6, 5'd15: r = "^";
        5'd9:  r = "A";
        5'd10: r = "Q";
        5'd11: r = "R";
        5'd13: r = "\\";
        5'd14: r = "]";
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/hnc_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the Hangul converter: valid/ready handshake with action and byte.
// Depends on nothing.
interface hnc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

// ----- hw/rtl/hnc_out_if.sv -----
`timescale 1ns / 1ps
// Output channel of the Hangul converter: valid/ready handshake with one result byte.
// Depends on nothing.
interface hnc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- hw/rtl/hangul_three_byte_to_nbyte_converter.sv -----
`timescale 1ns / 1ps
// Hangul three-byte to shift-code converter, top level.
// Depends on hnc_pkg, hnc_in_if, hnc_out_if, hnc_decode and hnc_serial.
//
// Usage: input items arrive on in_chan (action, in_byte) and result items
// leave on out_chan (out_byte, last_of_run), both with a valid/ready
// handshake. An item is taken at a rising edge where valid and ready are
// both high. A data item either passes its byte through, opens or extends
// a three-byte syllable, or completes a syllable and yields its letters.
// An end-of-line item closes Korean mode and yields a newline.
//
// The first result of an item is offered in the cycle after the item is
// taken. An item yields at most six results, and the single result
// register sends one byte a cycle while the receiver is ready. The next
// item is taken in the same cycle as the final result of the previous
// one leaves.
//
// Reset (rst, synchronous) returns the block to ASCII mode with no syllable
// pending and empties the result register. When the receiver stalls, the
// current result holds steady and in_chan.ready stays low until the
// final result of the batch held has been taken.
module hangul_three_byte_to_nbyte_converter
  import hnc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  hnc_in_if.sink    in_chan,
  hnc_out_if.source out_chan
);

  batch_t batch;
  logic   can_load;
  logic   accept;

  // A new item is taken only when the result register is free or frees now.
  assign in_chan.ready = can_load;
  assign accept        = in_chan.valid && can_load;

  hnc_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .action  (in_chan.action),
    .in_byte (in_chan.in_byte),
    .batch   (batch)
  );

  hnc_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .batch_in (batch),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

// ----- hw/rtl/hnc_decode.sv -----
`timescale 1ns / 1ps
// Line state (mode, syllable phase, held jamo codes) and result batch builder.
// Depends on hnc_pkg.
module hnc_decode
  import hnc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       action,
  input  logic [7:0] in_byte,
  output batch_t     batch
);

  logic       korean_mode;
  logic [1:0] syllable_phase;
  logic [7:0] initial_code;
  logic [7:0] medial_code;

  logic       korean_mode_next;
  logic [1:0] syllable_phase_next;

  logic [7:0] l_init;
  logic [7:0] l_med;
  logic [7:0] l_medx;
  logic [7:0] l_fin;
  logic [7:0] l_finx;

  assign l_init = initial_letter(initial_code);
  assign l_med  = medial_letter(medial_code);
  assign l_medx = medial_extra_letter(medial_code);
  assign l_fin  = final_letter(in_byte);
  assign l_finx = final_extra_letter(in_byte);

  always_comb begin
    korean_mode_next    = korean_mode;
    syllable_phase_next = syllable_phase;
    batch.mask          = '0;
    batch.bytes         = '0;
    if (action == ACT_EOL) begin
      syllable_phase_next = PH_NONE;
      korean_mode_next    = 1'b0;
      batch.mask[0]       = korean_mode;
      batch.bytes[0]      = SHIFT_IN;
      batch.mask[1]       = 1'b1;
      batch.bytes[1]      = NEWLINE;
    end else if (syllable_phase == PH_INITIAL) begin
      syllable_phase_next = PH_MEDIAL;
    end else if (syllable_phase == PH_MEDIAL) begin
      // Third byte of a syllable: emit its letters, empty slots are skipped.
      syllable_phase_next = PH_NONE;
      korean_mode_next    = 1'b1;
      batch.mask[0]       = !korean_mode;
      batch.bytes[0]      = SHIFT_OUT;
      batch.mask[1]       = |l_init;
      batch.bytes[1]      = l_init;
      batch.mask[2]       = |l_med;
      batch.bytes[2]      = l_med;
      batch.mask[3]       = |l_medx;
      batch.bytes[3]      = l_medx;
      batch.mask[4]       = |l_fin;
      batch.bytes[4]      = l_fin;
      batch.mask[5]       = |l_finx;
      batch.bytes[5]      = l_finx;
    end else if (in_byte[7]) begin
      syllable_phase_next = PH_INITIAL;
    end else begin
      syllable_phase_next = PH_NONE;
      korean_mode_next    = 1'b0;
      batch.mask[0]       = korean_mode;
      batch.bytes[0]      = SHIFT_IN;
      batch.mask[1]       = 1'b1;
      batch.bytes[1]      = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      korean_mode    <= 1'b0;
      syllable_phase <= PH_NONE;
      initial_code   <= 8'h00;
      medial_code    <= 8'h00;
    end else if (accept) begin
      korean_mode    <= korean_mode_next;
      syllable_phase <= syllable_phase_next;
      if (action == ACT_DATA && syllable_phase == PH_NONE && in_byte[7]) begin
        initial_code <= in_byte;
      end
      if (action == ACT_DATA && syllable_phase == PH_INITIAL) begin
        medial_code <= in_byte;
      end
    end
  end

endmodule

// ----- hw/rtl/hnc_serial.sv -----
`timescale 1ns / 1ps
// Result register: holds one batch and sends its marked slots one per cycle while the receiver is ready.
// Depends on hnc_pkg and hnc_out_if.
module hnc_serial
  import hnc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  batch_t           batch_in,
  output logic             can_load,
  hnc_out_if.source        out_chan
);

  logic [BATCH_SLOTS-1:0]      mask;
  logic [BATCH_SLOTS-1:0]      mask_next;
  logic [BATCH_SLOTS-1:0][7:0] bytes;
  logic [BATCH_SLOTS-1:0]      rest;
  logic [2:0]                  sel;
  logic                        single;
  logic                        take;

  // Lowest marked slot goes out first.
  always_comb begin
    sel = '0;
    for (int i = BATCH_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign rest   = mask & (mask - BATCH_SLOTS'(1));
  assign single = (rest == '0);

  assign out_chan.valid       = |mask;
  assign out_chan.out_byte    = bytes[sel];
  assign out_chan.last_of_run = single;

  assign take     = out_chan.valid && out_chan.ready;
  assign can_load = (mask == '0) || (take && single);

  always_comb begin
    if (load) begin
      mask_next = batch_in.mask;
    end else if (take) begin
      mask_next = rest;
    end else begin
      mask_next = mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= batch_in.bytes;
    end
  end

endmodule

// ----- dv/hangul_conversion_checker.sv -----
`timescale 1ns / 1ps
// Checker for the Hangul converter: watches both channels, predicts each result byte and compares.
// Depends on hnc_pkg, hnc_in_if and hnc_out_if.
module hangul_conversion_checker
  import hnc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  hnc_in_if    in_chan,
  hnc_out_if   out_chan,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count
);

  localparam int CODE_BASE = 128;

  // Jamo letter tables, one character per code offset; a dash marks an empty entry.
  localparam logic [7:0] NO_LETTER = "-";
  localparam string INITIAL_LETTERS      = "-ABDGHIQRSUVWXYZ[\\]^";
  localparam string MEDIAL_LETTERS       = "-bcdefgjkllllrsssswzz|";
  localparam string MEDIAL_EXTRA_LETTERS = "----------bc|--fg|--|-";
  localparam string FINAL_LETTERS        = "-ABADDDGIIIIIIIIQRRUVWXZ[\\]^";
  localparam string FINAL_EXTRA_LETTERS  = "---U-X^--AQRU\\]^--U---------";

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } conv_byte_t;

  conv_byte_t expected_bytes [$];

  logic       korean = 1'b0;
  logic [1:0] phase = PH_NONE;
  logic [7:0] held_initial = 8'h00;
  logic [7:0] held_medial = 8'h00;
  int         mismatches = 0;
  int         checked = 0;

  function automatic logic [7:0] jamo_letter(input string letters, input logic [7:0] code);
    logic [7:0] c;
    c = NO_LETTER;
    if (code > CODE_BASE && code < CODE_BASE + letters.len())
      c = letters[code - CODE_BASE];
    return (c == NO_LETTER) ? 8'h00 : c;
  endfunction

  // Advances the converter state by one input item and queues the bytes it yields.
  function automatic void convert_item(input logic act, input logic [7:0] b);
    logic [7:0] run [$];
    logic [7:0] letters [5];
    if (act == ACT_EOL) begin
      phase = PH_NONE;
      if (korean) run.push_back(SHIFT_IN);
      run.push_back(NEWLINE);
      korean = 1'b0;
    end else if (phase == PH_INITIAL) begin
      held_medial = b;
      phase = PH_MEDIAL;
    end else if (phase == PH_MEDIAL) begin
      phase = PH_NONE;
      if (!korean) run.push_back(SHIFT_OUT);
      letters[0] = jamo_letter(INITIAL_LETTERS, held_initial);
      letters[1] = jamo_letter(MEDIAL_LETTERS, held_medial);
      letters[2] = jamo_letter(MEDIAL_EXTRA_LETTERS, held_medial);
      letters[3] = jamo_letter(FINAL_LETTERS, b);
      letters[4] = jamo_letter(FINAL_EXTRA_LETTERS, b);
      foreach (letters[i])
        if (letters[i] != 8'h00) run.push_back(letters[i]);
      korean = 1'b1;
    end else if (b[7]) begin
      phase = PH_INITIAL;
      held_initial = b;
    end else begin
      phase = PH_NONE;
      if (korean) run.push_back(SHIFT_IN);
      run.push_back(b);
      korean = 1'b0;
    end
    foreach (run[i])
      expected_bytes.push_back('{out_byte: run[i], last_of_run: (i == run.size() - 1)});
  endfunction

  // Results are compared before the item of the same edge is predicted, since
  // an item's first result cannot leave in the cycle it is taken.
  always @(posedge clk) begin : track
    conv_byte_t want;
    if (rst) begin
      expected_bytes.delete();
      korean = 1'b0;
      phase = PH_NONE;
      held_initial = 8'h00;
      held_medial = 8'h00;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result item: out_byte 0x%02h, last_of_run %0b",
                 out_chan.out_byte, out_chan.last_of_run);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          checked++;
          if (out_chan.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.out_byte, out_chan.out_byte);
            mismatches++;
          end
          if (out_chan.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                   out_chan.last_of_run);
            mismatches++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready)
        convert_item(in_chan.action, in_chan.in_byte);
    end
    fail_count    <= mismatches;
    pending_count <= expected_bytes.size();
    checked_count <= checked;
  end

endmodule

// ----- dv/hangul_three_byte_to_nbyte_converter_tb.sv -----
`timescale 1ns / 1ps
// Top of the Hangul converter testbench: clock, reset, stimulus, result receiver and verdict.
// Depends on hnc_pkg, hnc_in_if, hnc_out_if, hangul_conversion_checker and the converter.
module hangul_three_byte_to_nbyte_converter_tb
  import hnc_pkg::*;
();

  // A correct run never goes this many cycles without an item moving on
  // either channel: sender gaps and receiver stalls are bounded far below
  // it and the block answers in the cycle after it takes an item.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles allowed after the last expected result, to catch any stray item.
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_ITEMS   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hnc_in_if  in_chan ();
  hnc_out_if out_chan ();

  int fail_count;
  int pending_count;
  int checked_count;
  int items_sent = 0;
  int lines_sent = 0;
  // When set, the sender offers items back to back for the current line.
  logic send_calm = 1'b0;

  hangul_three_byte_to_nbyte_converter dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  hangul_conversion_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offers one item after a random gap and returns at the edge where it is
  // taken. With no gap, valid simply stays high for the next item.
  task automatic send_item(input logic act, input logic [7:0] b);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.action  <= act;
    in_chan.in_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (act == ACT_EOL) lines_sent++;
  endtask

  task automatic send_syllable(input logic [7:0] ini, input logic [7:0] med,
                               input logic [7:0] fin);
    send_item(ACT_DATA, ini);
    send_item(ACT_DATA, med);
    send_item(ACT_DATA, fin);
  endtask

  // Holds the sender back until the checker has seen every result it
  // expects. The first wait lets the checker count the item just taken.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // An opening byte always has its top bit set; mostly it lies near the
  // table range so that real letters come out, sometimes anywhere above.
  function automatic logic [7:0] random_initial();
    if ($urandom_range(0, 3) == 0)
      return 8'h80 | 8'($urandom_range(0, 127));
    return 8'h80 | 8'($urandom_range(0, 31));
  endfunction

  // Medial and final bytes are taken as codes whatever their value, so now
  // and then any byte at all is used, top bit clear and zero included.
  function automatic logic [7:0] random_jamo();
    if ($urandom_range(0, 3) == 0)
      return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 31));
  endfunction

  // The receiver stalls a random number of cycles before each result, and
  // now and then switches to a calm spell in which it never stalls.
  initial begin : result_receiver
    int   stall;
    logic recv_calm;
    recv_calm = 1'b0;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
    end
  end

  // Ends the run as a failure if the channels stay still for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int random_start;
    int tokens;
    in_chan.valid   = 1'b0;
    in_chan.action  = ACT_DATA;
    in_chan.in_byte = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A plain letter and a zero byte pass through in ASCII mode.
    send_item(ACT_DATA, 8'h48);
    send_item(ACT_DATA, 8'h00);
    // From ASCII mode a syllable whose every table gives a letter yields the
    // most results an item can cause: shift-out and five letters.
    send_syllable(8'h93, 8'h8C, 8'h8F);
    // All three codes at the base are outside every table; already in Korean
    // mode this syllable yields no result at all.
    send_syllable(8'h80, 8'h80, 8'h80);
    // Initial out of range, a zero medial byte with its top bit clear, and
    // the highest final code.
    send_syllable(8'hFF, 8'h00, 8'h9B);
    // Leaving Korean mode: shift-in, then the byte.
    send_item(ACT_DATA, 8'h7F);
    // From ASCII mode an empty syllable still yields the shift-out.
    send_syllable(8'h80, 8'h80, 8'h80);
    // End of line in Korean mode, then again in ASCII mode with a set byte.
    send_item(ACT_EOL, 8'h00);
    send_item(ACT_EOL, 8'hFF);
    // Codes one past the end of each table.
    send_syllable(8'h94, 8'h96, 8'h9C);
    // Unfinished syllables are dropped at end of line, after one and two bytes.
    send_item(ACT_DATA, 8'hC5);
    send_item(ACT_EOL, 8'h5A);
    send_item(ACT_DATA, 8'h81);
    send_item(ACT_DATA, 8'h82);
    send_item(ACT_EOL, 8'h00);
    drain_results();

    // Random part: lines made mostly of well-formed syllables and plain
    // bytes, with the odd line cut off in the middle of a syllable.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      send_calm = ($urandom_range(0, 3) == 0);
      tokens = $urandom_range(0, 10);
      repeat (tokens) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_syllable(random_initial(), random_jamo(), random_jamo());
          6, 7, 8: send_item(ACT_DATA, 8'($urandom_range(0, 127)));
          default: begin
            send_item(ACT_DATA, random_initial());
            if ($urandom_range(0, 1) == 1) send_item(ACT_DATA, random_jamo());
            send_item(ACT_EOL, 8'($urandom_range(0, 255)));
          end
        endcase
      end
      send_item(ACT_EOL, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    send_calm = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d input items over %0d line ends; %0d result items were checked.",
             items_sent, lines_sent, checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
